>>> rtl/core/ddo_pkg.sv
package ddo_pkg;

    // Field widths
    localparam int WORD_W  = 32;
    localparam int ANG_W   = 24;
    localparam int ADDR_W  = 5;
    localparam int ATAN_IW = 5;

    // CORDIC start vector: inverse gain in Q30
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    // Register reset values
    localparam logic [WORD_W-1:0] DIST_RESET = 32'd16777216;
    localparam logic [WORD_W-1:0] TURN_RESET = 32'd65536;

    // Register indexes
    typedef enum logic [2:0] {
        REG_DIST    = 3'd0,
        REG_TURN    = 3'd1,
        REG_START_X = 3'd2,
        REG_START_Y = 3'd3,
        REG_START_H = 3'd4
    } ddo_reg_idx_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD_MUL,
        S_HEAD_ADD,
        S_TRAV,
        S_ROT,
        S_MUL_X,
        S_MUL_Y,
        S_ADD_Y,
        S_OUT
    } ddo_state_t;

    // Shared multiplier operand select
    typedef enum logic [1:0] {
        MSEL_HEAD,
        MSEL_TRAV,
        MSEL_X,
        MSEL_Y
    } ddo_mul_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic         take_in;
        ddo_mul_sel_t mul_sel;
        logic         head_upd;
        logic         trav_upd;
        logic         cordic_init;
        logic         cordic_step;
        logic         x_upd;
        logic         y_upd;
        logic         load_out;
    } ddo_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic rot_last;
    } ddo_stat_t;

    // Scale settings from the register file
    typedef struct packed {
        logic [WORD_W-1:0] dist_per_tick;
        logic [WORD_W-1:0] turn_scale;
    } ddo_cfg_t;

    // Pose load strobes from register writes
    typedef struct packed {
        logic              ld_x;
        logic              ld_y;
        logic              ld_h;
        logic [WORD_W-1:0] value;
    } ddo_load_t;

    // Arctangent of 2^-i in 32-bit binary angle units
    function automatic logic [31:0] atan_entry(input logic [ATAN_IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/ddo_regs.sv
module ddo_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0]  paddr,
    input  logic [ddo_pkg::WORD_W-1:0]  pwdata,
    output logic [ddo_pkg::WORD_W-1:0]  prdata,
    output ddo_pkg::ddo_cfg_t           cfg,
    output ddo_pkg::ddo_load_t          load
);
    import ddo_pkg::*;

    logic [WORD_W-1:0] dist_reg;
    logic [WORD_W-1:0] turn_reg;
    logic [WORD_W-1:0] start_x_reg;
    logic [WORD_W-1:0] start_y_reg;
    logic [ANG_W-1:0]  start_h_reg;
    logic              wr_en;
    ddo_reg_idx_t      idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = ddo_reg_idx_t'(paddr[ADDR_W-1:2]);

    // Write the addressed register; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg    <= DIST_RESET;
            turn_reg    <= TURN_RESET;
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_h_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_DIST:    dist_reg    <= pwdata;
                REG_TURN:    turn_reg    <= pwdata;
                REG_START_X: start_x_reg <= pwdata;
                REG_START_Y: start_y_reg <= pwdata;
                REG_START_H: start_h_reg <= pwdata[ANG_W-1:0];
                default:     ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_DIST:    prdata = dist_reg;
            REG_TURN:    prdata = turn_reg;
            REG_START_X: prdata = start_x_reg;
            REG_START_Y: prdata = start_y_reg;
            REG_START_H: prdata = {{(WORD_W-ANG_W){1'b0}}, start_h_reg};
            default:     prdata = '0;
        endcase
    end

    // Scale settings and pose load strobes
    assign cfg.dist_per_tick = dist_reg;
    assign cfg.turn_scale    = turn_reg;
    assign load.ld_x  = wr_en && (idx == REG_START_X);
    assign load.ld_y  = wr_en && (idx == REG_START_Y);
    assign load.ld_h  = wr_en && (idx == REG_START_H);
    assign load.value = pwdata;

endmodule

>>> rtl/core/ddo_ctrl.sv
module ddo_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ddo_pkg::ddo_stat_t  stat,
    output ddo_pkg::ddo_cmd_t   cmd
);
    import ddo_pkg::*;

    ddo_state_t state_reg;
    ddo_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_HEAD_MUL;
            S_HEAD_MUL: state_next = S_HEAD_ADD;
            S_HEAD_ADD: state_next = S_TRAV;
            S_TRAV:     state_next = S_ROT;
            S_ROT:      if (stat.rot_last) state_next = S_MUL_X;
            S_MUL_X:    state_next = S_MUL_Y;
            S_MUL_Y:    state_next = S_ADD_Y;
            S_ADD_Y:    state_next = S_OUT;
            S_OUT:      if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MSEL_HEAD;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.take_in = in_valid;
            end
            S_HEAD_MUL: cmd.mul_sel = MSEL_HEAD;
            S_HEAD_ADD:
            begin
                cmd.head_upd = 1'b1;
                cmd.mul_sel  = MSEL_TRAV;
            end
            S_TRAV:
            begin
                cmd.trav_upd    = 1'b1;
                cmd.cordic_init = 1'b1;
            end
            S_ROT:      cmd.cordic_step = 1'b1;
            S_MUL_X:    cmd.mul_sel = MSEL_X;
            S_MUL_Y:
            begin
                cmd.x_upd   = 1'b1;
                cmd.mul_sel = MSEL_Y;
            end
            S_ADD_Y:    cmd.y_upd = 1'b1;
            S_OUT:      cmd.load_out = out_free;
            default:    ;
        endcase
    end

    // Hold the result until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/ddo_dp.sv
module ddo_dp #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ddo_pkg::ddo_cmd_t                 cmd,
    output ddo_pkg::ddo_stat_t                stat,
    input  ddo_pkg::ddo_cfg_t                 cfg,
    input  ddo_pkg::ddo_load_t                load,
    input  logic signed [ddo_pkg::WORD_W-1:0] left_count,
    input  logic signed [ddo_pkg::WORD_W-1:0] right_count,
    output logic signed [ddo_pkg::WORD_W-1:0] pos_x,
    output logic signed [ddo_pkg::WORD_W-1:0] pos_y,
    output logic        [ddo_pkg::ANG_W-1:0]  heading
);
    import ddo_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    // Pose and previous counts
    logic [WORD_W-1:0] prev_left_reg;
    logic [WORD_W-1:0] prev_right_reg;
    logic [WORD_W-1:0] acc_x_reg;
    logic [WORD_W-1:0] acc_y_reg;
    logic [ANG_W-1:0]  acc_h_reg;
    logic [WORD_W-1:0] acc_x_next;
    logic [WORD_W-1:0] acc_y_next;
    logic [ANG_W-1:0]  acc_h_next;

    // Work registers
    logic signed [WORD_W:0]   sum_reg;
    logic [WORD_W-1:0]        diff_reg;
    logic signed [65:0]       prod_reg;
    logic signed [WORD_W-1:0] travel_reg;
    logic signed [WORD_W-1:0] travel_next;
    logic signed [33:0]       x_reg;
    logic signed [33:0]       y_reg;
    logic signed [33:0]       z_reg;
    logic signed [33:0]       x_next;
    logic signed [33:0]       y_next;
    logic signed [33:0]       z_next;
    logic                     flip_reg;
    logic [STEP_W-1:0]        step_reg;

    // Output payload
    logic [WORD_W-1:0] pos_x_reg;
    logic [WORD_W-1:0] pos_y_reg;
    logic [ANG_W-1:0]  heading_reg;

    // Wrapping deltas
    logic signed [WORD_W-1:0] dl;
    logic signed [WORD_W-1:0] dr;

    assign dl = left_count - prev_left_reg;
    assign dr = right_count - prev_right_reg;

    // Magnitude of the tick sum; top bit set only for the most negative sum
    logic [WORD_W:0] mag;

    assign mag = sum_reg[WORD_W] ? (WORD_W+1)'(-sum_reg) : sum_reg;

    // Cosine and sine after quadrant fold-back
    logic signed [33:0] cos_w;
    logic signed [33:0] sin_w;

    assign cos_w = flip_reg ? -x_reg : x_reg;
    assign sin_w = flip_reg ? -y_reg : y_reg;

    // Shared multiplier
    logic signed [WORD_W:0] mul_a;
    logic signed [WORD_W:0] mul_b;
    logic signed [65:0]     mul_p;

    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_HEAD:
            begin
                mul_a = {1'b0, diff_reg};
                mul_b = {1'b0, cfg.turn_scale};
            end
            MSEL_TRAV:
            begin
                mul_a = {1'b0, mag[WORD_W-1:0]};
                mul_b = {1'b0, cfg.dist_per_tick};
            end
            MSEL_X:
            begin
                mul_a = {travel_reg[WORD_W-1], travel_reg};
                mul_b = cos_w[WORD_W:0];
            end
            MSEL_Y:
            begin
                mul_a = {travel_reg[WORD_W-1], travel_reg};
                mul_b = sin_w[WORD_W:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Travel: add the 2^32 term, drop nine bits, saturate
    logic [64:0] trav_full;
    logic [55:0] trav_mag;

    assign trav_full = {1'b0, prod_reg[63:0]}
                     + (mag[WORD_W] ? {1'b0, cfg.dist_per_tick, 32'b0} : 65'd0);
    assign trav_mag  = trav_full[64:9];

    always_comb
    begin
        if (sum_reg[WORD_W])
        begin
            if (trav_mag > 56'h80000000)
                travel_next = 32'sh80000000;
            else
                travel_next = -trav_mag[WORD_W-1:0];
        end
        else
        begin
            if (trav_mag > 56'h7FFFFFFF)
                travel_next = 32'sh7FFFFFFF;
            else
                travel_next = trav_mag[WORD_W-1:0];
        end
    end

    // CORDIC start angle, folded into the right half plane
    logic [31:0] z32;
    logic        flip_w;
    logic [31:0] z32_fold;

    assign z32      = {acc_h_reg, 8'b0};
    assign flip_w   = z32[31] ^ z32[30];
    assign z32_fold = {z32[31] ^ flip_w, z32[30:0]};

    // One CORDIC rotation per cycle
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] atan_w;

    assign xs     = x_reg >>> step_reg;
    assign ys     = y_reg >>> step_reg;
    assign atan_w = {2'b00, atan_entry(ATAN_IW'(step_reg))};

    always_comb
    begin
        if (!z_reg[33])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_w;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_w;
        end
    end

    assign stat.rot_last = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    // Pose next values; a register write loads the start value
    always_comb
    begin
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        acc_h_next = acc_h_reg;
        if (load.ld_x)
            acc_x_next = load.value;
        else if (cmd.x_upd)
            acc_x_next = acc_x_reg + prod_reg[61:30];
        if (load.ld_y)
            acc_y_next = load.value;
        else if (cmd.y_upd)
            acc_y_next = acc_y_reg + prod_reg[61:30];
        if (load.ld_h)
            acc_h_next = load.value[ANG_W-1:0];
        else if (cmd.head_upd)
            acc_h_next = acc_h_reg + prod_reg[31:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            acc_h_reg      <= '0;
        end
        else
        begin
            if (cmd.take_in)
            begin
                prev_left_reg  <= left_count;
                prev_right_reg <= right_count;
            end
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            acc_h_reg <= acc_h_next;
        end
    end

    // Work registers and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            sum_reg  <= {dl[WORD_W-1], dl} + {dr[WORD_W-1], dr};
            diff_reg <= dr - dl;
        end
        prod_reg <= mul_p;
        if (cmd.trav_upd)
            travel_reg <= travel_next;
        if (cmd.cordic_init)
        begin
            x_reg    <= GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= {{2{z32_fold[31]}}, z32_fold};
            flip_reg <= flip_w;
            step_reg <= '0;
        end
        else if (cmd.cordic_step)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            pos_x_reg   <= acc_x_reg;
            pos_y_reg   <= acc_y_reg;
            heading_reg <= acc_h_reg;
        end
    end

    assign pos_x   = pos_x_reg;
    assign pos_y   = pos_y_reg;
    assign heading = heading_reg;

endmodule

>>> rtl/core/differential_drive_odometry_core.sv
// One request at a time: in_ready is high only in the idle state. The iterative
// CORDIC rotator, one rotation per cycle, and the shared 33x33 multiplier work
// through each request in turn before the next one is taken.
// A new request is taken while the previous result still waits at the output.
// Reset (rst_n low, asynchronous): pose, previous counts and start registers clear,
// scale registers return to 1.0 cm per tick and 256 angle units per tick.
module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0]        paddr,
    input  logic [ddo_pkg::WORD_W-1:0]        pwdata,
    output logic [ddo_pkg::WORD_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ddo_pkg::WORD_W-1:0] left_count,
    input  logic signed [ddo_pkg::WORD_W-1:0] right_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ddo_pkg::WORD_W-1:0] pos_x,
    output logic signed [ddo_pkg::WORD_W-1:0] pos_y,
    output logic        [ddo_pkg::ANG_W-1:0]  heading
);
    import ddo_pkg::*;

    ddo_cfg_t  cfg;
    ddo_load_t load;
    ddo_cmd_t  cmd;
    ddo_stat_t stat;

    assign pready = 1'b1;

    // Register file
    ddo_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .load    (load)
    );

    // Sequencer
    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic
    ddo_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg         (cfg),
        .load        (load),
        .left_count  (left_count),
        .right_count (right_count),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading)
    );

endmodule

>>> rtl/core/ddo_checker.sv
module ddo_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ddo_pkg::WORD_W-1:0] pos_x,
    input logic signed [ddo_pkg::WORD_W-1:0] pos_y,
    input logic        [ddo_pkg::ANG_W-1:0]  heading
);
    import ddo_pkg::*;

    // One request at a time: busy right after a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pos_x)
                                       && $stable(pos_y) && $stable(heading)))
        else $error("stalled result changed");

    // A result appears only at the end of a busy period
    a_rise_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (!$past(in_ready, 1) && !$past(in_ready, 8)))
        else $error("result without preceding work");

    // A presented result carries known values
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({pos_x, pos_y, heading}))
        else $error("result has unknown bits");

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (.*);
